// ===== hdl/bmp_rpu_pkg.sv =====
`timescale 1ns / 1ps

package bmp_rpu_pkg;

   typedef logic [1:0]  action_type;
   typedef logic [7:0]  chan_type;
   typedef logic [11:0] coord_type;
   typedef logic [12:0] dim_type;
   typedef logic [23:0] rgb_type;

   localparam action_type ACT_PAL_WRITE = 2'd0;
   localparam action_type ACT_PIXEL     = 2'd1;
   localparam action_type ACT_RESTART   = 2'd2;

   localparam logic [1:0] DEPTH_1  = 2'd0;
   localparam logic [1:0] DEPTH_4  = 2'd1;
   localparam logic [1:0] DEPTH_8  = 2'd2;
   localparam logic [1:0] DEPTH_24 = 2'd3;

   localparam logic [1:0] REG_DEPTH  = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   localparam int      PALETTE_DEPTH = 256;
   localparam dim_type MAX_WIDTH     = 13'd4096;
   localparam dim_type MAX_HEIGHT    = 13'd4096;

endpackage

// ===== hdl/bmp_rpu_req_if.sv =====
`timescale 1ns / 1ps

interface bmp_rpu_req_if;
   logic                    valid;
   logic                    ready;
   bmp_rpu_pkg::action_type action;
   bmp_rpu_pkg::chan_type   data_byte;
   bmp_rpu_pkg::chan_type   palette_index;
   bmp_rpu_pkg::chan_type   palette_red;
   bmp_rpu_pkg::chan_type   palette_green;
   bmp_rpu_pkg::chan_type   palette_blue;

   modport source (
      output valid, action, data_byte, palette_index, palette_red, palette_green,
             palette_blue,
      input  ready
   );

   modport sink (
      input  valid, action, data_byte, palette_index, palette_red, palette_green,
             palette_blue,
      output ready
   );
endinterface

// ===== hdl/bmp_rpu_rsp_if.sv =====
`timescale 1ns / 1ps

interface bmp_rpu_rsp_if;
   logic                   valid;
   logic                   ready;
   bmp_rpu_pkg::chan_type  red;
   bmp_rpu_pkg::chan_type  green;
   bmp_rpu_pkg::chan_type  blue;
   bmp_rpu_pkg::coord_type column;
   bmp_rpu_pkg::coord_type row;
   logic                   last_of_run;
   logic                   frame_done;

   modport source (
      output valid, red, green, blue, column, row, last_of_run, frame_done,
      input  ready
   );

   modport sink (
      input  valid, red, green, blue, column, row, last_of_run, frame_done,
      output ready
   );
endinterface

// ===== hdl/bmp_row_pixel_unpacker_unit.sv =====
`timescale 1ns / 1ps

// Bitmap row pixel unpacker.
// req_bus takes one word per handshake: a palette write, a raw pixel data byte
// or a restart of the column, row, padding and byte phase state (palette kept).
// rsp_bus returns one decoded pixel per word with its column, row, a flag on
// the last pixel of its byte or row and a flag on the final pixel of the image.
// An APB port (psel ... pready) sets depth, width and height; write it idle.
// An accepted data byte goes to the unpack register, then each pixel with its
// palette read to the output word. The single palette read port gives one pixel
// per cycle unless rsp_bus stalls; a byte holds 8 at 1 bit, 2 at 4 bits and 1
// at 8 bits; at 24 bits one pixel comes out for every third byte, one byte per
// cycle unless stalled. A new word is taken in the cycle the previous byte
// issues its last pixel. Padding bytes, palette writes and restarts give no
// word. A stalled rsp_bus holds the current pixel; the next pixel waits in the
// unpack register and the palette read data register stays unchanged.
// Reset clears counters and registers to depth 8 bits, width 1, height 1;
// the palette is undefined until written and needs no clearing pass.

module bmp_row_pixel_unpacker_unit (
   input  logic                clock,
   input  logic                reset,
   bmp_rpu_req_if.sink         req_bus,
   bmp_rpu_rsp_if.source       rsp_bus,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam logic [1:0] PHASE_BLUE  = 2'd0;
   localparam logic [1:0] PHASE_GREEN = 2'd1;
   localparam logic [1:0] PHASE_RED   = 2'd2;

   logic [1:0]               depth_ff;
   bmp_rpu_pkg::dim_type     width_ff;
   bmp_rpu_pkg::dim_type     height_ff;
   logic                     cfg_we;

   bmp_rpu_pkg::dim_type     w_eff;
   bmp_rpu_pkg::dim_type     h_eff;

   bmp_rpu_pkg::coord_type   col_ff, col_in;
   bmp_rpu_pkg::coord_type   row_ff, row_in;
   logic [1:0]               pad_ff, pad_in;
   logic [1:0]               phase_ff, phase_in;
   bmp_rpu_pkg::chan_type    held_blue_ff, held_blue_in;
   bmp_rpu_pkg::chan_type    held_green_ff, held_green_in;

   logic                     wk_valid_ff, wk_valid_in;
   bmp_rpu_pkg::chan_type    wk_byte_ff, wk_byte_in;
   logic [2:0]               wk_pos_ff, wk_pos_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   bmp_rpu_pkg::coord_type   out_col_ff;
   bmp_rpu_pkg::coord_type   out_row_ff;
   logic                     out_last_ff;
   logic                     out_frame_ff;
   logic                     out_direct_ff;
   bmp_rpu_pkg::rgb_type     out_rgb_ff;

   bmp_rpu_pkg::rgb_type     pal_mem [bmp_rpu_pkg::PALETTE_DEPTH];
   bmp_rpu_pkg::rgb_type     pal_q_ff;
   logic                     pal_we;
   logic                     pal_re;

   logic                     req_fire;
   logic                     issue;
   logic                     row_end;
   logic                     frame_end;
   logic                     pos_last;
   logic                     wk_last;
   bmp_rpu_pkg::chan_type    pix_idx;
   logic [4:0]               row_rem;
   logic [4:0]               row_rem_neg;
   logic [1:0]               pad_new;
   logic [1:0]               w3;

   // configuration port
   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= bmp_rpu_pkg::DEPTH_8;
         width_ff  <= 13'd1;
         height_ff <= 13'd1;
      end else if (cfg_we) begin
         case (paddr[3:2])
            bmp_rpu_pkg::REG_DEPTH:  depth_ff  <= pwdata[1:0];
            bmp_rpu_pkg::REG_WIDTH:  width_ff  <= pwdata[12:0];
            bmp_rpu_pkg::REG_HEIGHT: height_ff <= pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         bmp_rpu_pkg::REG_DEPTH:  prdata = {30'd0, depth_ff};
         bmp_rpu_pkg::REG_WIDTH:  prdata = {19'd0, width_ff};
         bmp_rpu_pkg::REG_HEIGHT: prdata = {19'd0, height_ff};
         default:                 prdata = 32'd0;
      endcase
   end

   always_comb begin
      if (width_ff == 13'd0) begin
         w_eff = 13'd1;
      end else if (width_ff > bmp_rpu_pkg::MAX_WIDTH) begin
         w_eff = bmp_rpu_pkg::MAX_WIDTH;
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == 13'd0) begin
         h_eff = 13'd1;
      end else if (height_ff > bmp_rpu_pkg::MAX_HEIGHT) begin
         h_eff = bmp_rpu_pkg::MAX_HEIGHT;
      end else begin
         h_eff = height_ff;
      end
   end

   // row padding: bytes up to the next 32-bit boundary
   assign w3 = 2'(w_eff[1:0] + {w_eff[0], 1'b0});

   always_comb begin
      case (depth_ff)
         bmp_rpu_pkg::DEPTH_1: row_rem = w_eff[4:0];
         bmp_rpu_pkg::DEPTH_4: row_rem = {w_eff[2:0], 2'b00};
         bmp_rpu_pkg::DEPTH_8: row_rem = {w_eff[1:0], 3'b000};
         default:              row_rem = {w3, 3'b000};
      endcase
   end

   assign row_rem_neg = 5'd0 - row_rem;
   assign pad_new     = row_rem_neg[4:3];

   // unpack register: pick the index of the current pixel
   always_comb begin
      case (depth_ff)
         bmp_rpu_pkg::DEPTH_1: begin
            pix_idx  = {7'd0, wk_byte_ff[3'd7 - wk_pos_ff]};
            pos_last = (wk_pos_ff == 3'd7);
         end
         bmp_rpu_pkg::DEPTH_4: begin
            pix_idx  = {4'd0, (wk_pos_ff[0] ? wk_byte_ff[3:0] : wk_byte_ff[7:4])};
            pos_last = wk_pos_ff[0];
         end
         default: begin
            pix_idx  = wk_byte_ff;
            pos_last = 1'b1;
         end
      endcase
   end

   assign issue     = wk_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign row_end   = ({1'b0, col_ff} + 13'd1) >= w_eff;
   assign frame_end = row_end && (({1'b0, row_ff} + 13'd1) >= h_eff);
   assign wk_last   = pos_last || row_end;

   assign req_bus.ready = !wk_valid_ff || (issue && wk_last);
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign pal_we = req_fire && (req_bus.action == bmp_rpu_pkg::ACT_PAL_WRITE);
   assign pal_re = issue && (depth_ff != bmp_rpu_pkg::DEPTH_24);

   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[req_bus.palette_index] <= {req_bus.palette_red, req_bus.palette_green,
                                            req_bus.palette_blue};
      end
      if (pal_re) begin
         pal_q_ff <= pal_mem[pix_idx];
      end
   end

   // counters: the issued pixel first, then the accepted word
   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      pad_in        = pad_ff;
      phase_in      = phase_ff;
      held_blue_in  = held_blue_ff;
      held_green_in = held_green_ff;
      wk_valid_in   = wk_valid_ff;
      wk_byte_in    = wk_byte_ff;
      wk_pos_in     = wk_pos_ff;

      if (issue) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : 12'(row_ff + 12'd1);
            pad_in = pad_new;
         end else begin
            col_in = 12'(col_ff + 12'd1);
         end
         wk_pos_in = 3'(wk_pos_ff + 3'd1);
         if (wk_last) begin
            wk_valid_in = 1'b0;
         end
      end

      if (req_fire) begin
         case (req_bus.action)
            bmp_rpu_pkg::ACT_RESTART: begin
               col_in        = '0;
               row_in        = '0;
               pad_in        = '0;
               phase_in      = PHASE_BLUE;
               held_blue_in  = '0;
               held_green_in = '0;
            end
            bmp_rpu_pkg::ACT_PIXEL: begin
               if (pad_in != 2'd0) begin
                  pad_in = 2'(pad_in - 2'd1);
               end else if (depth_ff == bmp_rpu_pkg::DEPTH_24) begin
                  case (phase_ff)
                     PHASE_GREEN: begin
                        held_green_in = req_bus.data_byte;
                        phase_in      = PHASE_RED;
                     end
                     PHASE_RED: begin
                        phase_in    = PHASE_BLUE;
                        wk_valid_in = 1'b1;
                        wk_byte_in  = req_bus.data_byte;
                        wk_pos_in   = '0;
                     end
                     default: begin
                        held_blue_in = req_bus.data_byte;
                        phase_in     = PHASE_GREEN;
                     end
                  endcase
               end else begin
                  wk_valid_in = 1'b1;
                  wk_byte_in  = req_bus.data_byte;
                  wk_pos_in   = '0;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid_in = issue || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         pad_ff        <= '0;
         phase_ff      <= PHASE_BLUE;
         held_blue_ff  <= '0;
         held_green_ff <= '0;
         wk_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         pad_ff        <= pad_in;
         phase_ff      <= phase_in;
         held_blue_ff  <= held_blue_in;
         held_green_ff <= held_green_in;
         wk_valid_ff   <= wk_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wk_byte_ff <= wk_byte_in;
      wk_pos_ff  <= wk_pos_in;
      if (issue) begin
         out_col_ff    <= col_ff;
         out_row_ff    <= row_ff;
         out_last_ff   <= wk_last;
         out_frame_ff  <= frame_end;
         out_direct_ff <= (depth_ff == bmp_rpu_pkg::DEPTH_24);
         out_rgb_ff    <= {wk_byte_ff, held_green_ff, held_blue_ff};
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.red         = out_direct_ff ? out_rgb_ff[23:16] : pal_q_ff[23:16];
   assign rsp_bus.green       = out_direct_ff ? out_rgb_ff[15:8]  : pal_q_ff[15:8];
   assign rsp_bus.blue        = out_direct_ff ? out_rgb_ff[7:0]   : pal_q_ff[7:0];
   assign rsp_bus.column      = out_col_ff;
   assign rsp_bus.row         = out_row_ff;
   assign rsp_bus.last_of_run = out_last_ff;
   assign rsp_bus.frame_done  = out_frame_ff;

   a_pad_at_row_start: assert property (@(posedge clock) disable iff (reset)
      (pad_ff != 2'd0) |-> (col_ff == '0))
      else $error("padding pending in the middle of a row");

   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("byte phase reached an unused code");

   a_read_lands: assert property (@(posedge clock) disable iff (reset)
      pal_re |=> rsp_valid_ff)
      else $error("palette read issued without an output word");

   a_no_issue_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |-> !issue)
      else $error("pixel issued over a stalled output word");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam bmp_rpu_pkg::action_type ACT_UNUSED = 2'd3;
   localparam int         CYCLE_LIMIT   = 250000;
   localparam int         SETTLE_CYCLES = 16;
   localparam int         HOLD_CYCLES   = 300;

   typedef struct {
      bmp_rpu_pkg::action_type action;
      bmp_rpu_pkg::chan_type   data_byte;
      bmp_rpu_pkg::chan_type   pal_index;
      bmp_rpu_pkg::chan_type   pal_red;
      bmp_rpu_pkg::chan_type   pal_green;
      bmp_rpu_pkg::chan_type   pal_blue;
   } bmp_word_type;

   typedef struct {
      bmp_rpu_pkg::chan_type  red;
      bmp_rpu_pkg::chan_type  green;
      bmp_rpu_pkg::chan_type  blue;
      bmp_rpu_pkg::coord_type column;
      bmp_rpu_pkg::coord_type row;
      logic                   last_of_run;
      logic                   frame_done;
   } pixel_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   bmp_rpu_req_if req_bus ();
   bmp_rpu_rsp_if rsp_bus ();

   bmp_row_pixel_unpacker_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // decoder state as the block should hold it
   logic [1:0]             cfg_depth;
   bmp_rpu_pkg::dim_type   cfg_width;
   bmp_rpu_pkg::dim_type   cfg_height;
   bmp_rpu_pkg::rgb_type   pal_mem [bmp_rpu_pkg::PALETTE_DEPTH];
   bmp_rpu_pkg::coord_type col_cnt;
   bmp_rpu_pkg::coord_type row_cnt;
   logic [1:0]             pad_left;
   logic [1:0]             rgb_phase;
   bmp_rpu_pkg::chan_type  held_blue;
   bmp_rpu_pkg::chan_type  held_green;

   pixel_type              pixels_due [$];
   bit                     pal_written [bmp_rpu_pkg::PALETTE_DEPTH];
   bmp_rpu_pkg::chan_type  pal_known [$];

   int send_idle_pct;
   int recv_idle_pct;
   bit rsp_hold;
   int fail_count;
   int cycle_count;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= !rsp_hold && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : check_pixels
      pixel_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pixels_due.size() == 0) begin
            $error("pixel word with none expected: column %0d row %0d",
                   rsp_bus.column, rsp_bus.row);
            fail_count++;
         end else begin
            want = pixels_due.pop_front();
            check_field("red", want.red, rsp_bus.red);
            check_field("green", want.green, rsp_bus.green);
            check_field("blue", want.blue, rsp_bus.blue);
            check_field("column", want.column, rsp_bus.column);
            check_field("row", want.row, rsp_bus.row);
            check_field("last_of_run", want.last_of_run, rsp_bus.last_of_run);
            check_field("frame_done", want.frame_done, rsp_bus.frame_done);
         end
      end
   end

   function automatic int unsigned depth_bits(logic [1:0] d);
      case (d)
         bmp_rpu_pkg::DEPTH_1: return 1;
         bmp_rpu_pkg::DEPTH_4: return 4;
         bmp_rpu_pkg::DEPTH_8: return 8;
         default: return 24;
      endcase
   endfunction

   function automatic int unsigned clamp_dim(bmp_rpu_pkg::dim_type v,
                                             bmp_rpu_pkg::dim_type limit);
      if (v == 0) return 1;
      if (v > limit) return 32'(limit);
      return 32'(v);
   endfunction

   function automatic bit emit_pixel(bmp_rpu_pkg::rgb_type color, bit last_in_byte);
      int unsigned w;
      int unsigned h;
      int unsigned rem;
      bit          row_end;
      bit          frame_end;
      pixel_type   px;
      w = clamp_dim(cfg_width, bmp_rpu_pkg::MAX_WIDTH);
      h = clamp_dim(cfg_height, bmp_rpu_pkg::MAX_HEIGHT);
      row_end = (col_cnt + 1 >= w);
      frame_end = row_end && (row_cnt + 1 >= h);
      px.red = color[23:16];
      px.green = color[15:8];
      px.blue = color[7:0];
      px.column = col_cnt;
      px.row = row_cnt;
      px.last_of_run = last_in_byte || row_end;
      px.frame_done = frame_end;
      pixels_due.push_back(px);
      if (row_end) begin
         rem = (w * depth_bits(cfg_depth)) % 32;
         if (rem != 0) pad_left = 2'((32 - rem) / 8);
         else pad_left = 2'd0;
         col_cnt = '0;
         if (frame_end) row_cnt = '0;
         else row_cnt = 12'(row_cnt + 1);
      end else begin
         col_cnt = 12'(col_cnt + 1);
      end
      return row_end;
   endfunction

   function automatic void decode_word(bmp_word_type w);
      int unsigned           bpp;
      int unsigned           per;
      int unsigned           mask;
      int unsigned           i;
      bmp_rpu_pkg::chan_type idx;
      case (w.action)
         bmp_rpu_pkg::ACT_PAL_WRITE: begin
            pal_mem[w.pal_index] = {w.pal_red, w.pal_green, w.pal_blue};
            if (!pal_written[w.pal_index]) begin
               pal_written[w.pal_index] = 1'b1;
               pal_known.push_back(w.pal_index);
            end
         end
         bmp_rpu_pkg::ACT_RESTART: begin
            col_cnt = '0;
            row_cnt = '0;
            pad_left = '0;
            rgb_phase = '0;
            held_blue = '0;
            held_green = '0;
         end
         bmp_rpu_pkg::ACT_PIXEL: begin
            if (pad_left != 0) begin
               pad_left = 2'(pad_left - 1);
            end else if (cfg_depth == bmp_rpu_pkg::DEPTH_24) begin
               if (rgb_phase == 2'd1) begin
                  held_green = w.data_byte;
                  rgb_phase = 2'd2;
               end else if (rgb_phase == 2'd2) begin
                  rgb_phase = 2'd0;
                  void'(emit_pixel({w.data_byte, held_green, held_blue}, 1'b1));
               end else begin
                  held_blue = w.data_byte;
                  rgb_phase = 2'd1;
               end
            end else begin
               bpp = depth_bits(cfg_depth);
               per = 8 / bpp;
               mask = (1 << bpp) - 1;
               for (i = 0; i < per; i++) begin
                  idx = 8'((w.data_byte >> (8 - bpp * (i + 1))) & mask);
                  if (emit_pixel(pal_mem[idx], i + 1 == per)) break;
               end
            end
         end
         default: ;
      endcase
   endfunction

   // keep 8-bit indices on entries already loaded
   function automatic bmp_rpu_pkg::chan_type next_data_byte();
      if (cfg_depth == bmp_rpu_pkg::DEPTH_8)
         return pal_known[$urandom_range(0, pal_known.size() - 1)];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic bmp_word_type pixel_word(bmp_rpu_pkg::chan_type value);
      bmp_word_type w;
      w.action = bmp_rpu_pkg::ACT_PIXEL;
      w.data_byte = value;
      w.pal_index = 8'($urandom_range(0, 255));
      w.pal_red = 8'($urandom_range(0, 255));
      w.pal_green = 8'($urandom_range(0, 255));
      w.pal_blue = 8'($urandom_range(0, 255));
      return w;
   endfunction

   function automatic bmp_word_type ctrl_word(bmp_rpu_pkg::action_type act);
      bmp_word_type w;
      w = pixel_word(8'($urandom_range(0, 255)));
      w.action = act;
      return w;
   endfunction

   function automatic bmp_word_type pal_word(bmp_rpu_pkg::chan_type idx,
                                             bmp_rpu_pkg::chan_type r,
                                             bmp_rpu_pkg::chan_type g,
                                             bmp_rpu_pkg::chan_type b);
      bmp_word_type w;
      w = ctrl_word(bmp_rpu_pkg::ACT_PAL_WRITE);
      w.pal_index = idx;
      w.pal_red = r;
      w.pal_green = g;
      w.pal_blue = b;
      return w;
   endfunction

   function automatic bmp_word_type random_pal_word();
      return pal_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endfunction

   task automatic send_word(bmp_word_type w);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.action = w.action;
      req_bus.data_byte = w.data_byte;
      req_bus.palette_index = w.pal_index;
      req_bus.palette_red = w.pal_red;
      req_bus.palette_green = w.pal_green;
      req_bus.palette_blue = w.pal_blue;
      do @(posedge clock); while (!req_bus.ready);
      decode_word(w);
   endtask

   task automatic csr_write(logic [1:0] reg_sel, logic [31:0] value);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {reg_sel, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (reg_sel)
         bmp_rpu_pkg::REG_DEPTH:  cfg_depth = value[1:0];
         bmp_rpu_pkg::REG_WIDTH:  cfg_width = value[12:0];
         bmp_rpu_pkg::REG_HEIGHT: cfg_height = value[12:0];
         default: ;
      endcase
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic apply_config(logic [1:0] depth, int unsigned width, int unsigned height);
      csr_write(bmp_rpu_pkg::REG_DEPTH, {30'd0, depth});
      csr_write(bmp_rpu_pkg::REG_WIDTH, width);
      csr_write(bmp_rpu_pkg::REG_HEIGHT, height);
   endtask

   // drop valid, drain pixels, then let the last word settle
   task automatic settle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      send_word(pal_word(8'h00, 8'h00, 8'h00, 8'h00));
      send_word(pal_word(8'hff, 8'hff, 8'hff, 8'hff));
      send_word(pal_word(8'h01, 8'h5a, 8'ha5, 8'h3c));
      send_word(pixel_word(8'hff));
      repeat (3) send_word(pixel_word(8'($urandom_range(0, 255))));
      send_word(ctrl_word(ACT_UNUSED));
      send_word(pixel_word(8'h00));
   endtask

   task automatic test_one_bit_rows();
      settle();
      apply_config(bmp_rpu_pkg::DEPTH_1, 13, 2);
      send_word(pixel_word(8'ha5));
      send_word(pixel_word(8'h5a));
      repeat (2) send_word(pixel_word(8'($urandom_range(0, 255))));
      send_word(ctrl_word(bmp_rpu_pkg::ACT_RESTART));
      send_word(pixel_word(8'hff));
   endtask

   task automatic test_true_color();
      settle();
      apply_config(bmp_rpu_pkg::DEPTH_24, 1, 1);
      send_word(pixel_word(8'h00));
      send_word(pixel_word(8'hff));
      send_word(pixel_word(8'h80));
      send_word(pixel_word(8'($urandom_range(0, 255))));
   endtask

   task automatic test_dim_limits();
      settle();
      apply_config(bmp_rpu_pkg::DEPTH_4, 0, 0);
      send_word(pixel_word(8'h10));
      settle();
      apply_config(bmp_rpu_pkg::DEPTH_4, 8191, 8191);
      send_word(ctrl_word(bmp_rpu_pkg::ACT_RESTART));
      repeat (2) send_word(pixel_word(8'h01));
      settle();
      csr_write(bmp_rpu_pkg::REG_WIDTH, 2);
      send_word(pixel_word(8'h10));
      settle();
      csr_write(bmp_rpu_pkg::REG_HEIGHT, 1);
      repeat (3) send_word(pixel_word(8'($urandom_range(0, 255))));
      send_word(pixel_word(8'h11));
   endtask

   task automatic load_palette();
      int i;
      for (i = 0; i < 16; i++)
         send_word(pal_word(8'(i), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255))));
      repeat (8) send_word(random_pal_word());
   endtask

   task automatic test_random_frames(int send_pct, int recv_pct, int quota);
      int          sent;
      int          r;
      int          b;
      logic [1:0]  d;
      int unsigned w;
      int unsigned h;
      int unsigned row_bytes;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < quota) begin
         settle();
         d = 2'($urandom_range(0, 3));
         if (d == bmp_rpu_pkg::DEPTH_24) w = $urandom_range(1, 8);
         else if ($urandom_range(0, 7) == 0) w = $urandom_range(25, 40);
         else w = $urandom_range(1, 24);
         h = $urandom_range(1, 3);
         apply_config(d, w, h);
         if ($urandom_range(0, 1) == 1) begin
            send_word(ctrl_word(bmp_rpu_pkg::ACT_RESTART));
            sent++;
         end
         row_bytes = ((w * depth_bits(d) + 31) / 32) * 4;
         for (r = 0; r < h && sent < quota; r++) begin
            for (b = 0; b < row_bytes; b++) begin
               if ($urandom_range(0, 15) == 0) begin
                  case ($urandom_range(0, 3))
                     0: send_word(ctrl_word(bmp_rpu_pkg::ACT_RESTART));
                     1: send_word(ctrl_word(ACT_UNUSED));
                     2: send_word(random_pal_word());
                     default: send_word(pixel_word(next_data_byte()));
                  endcase
                  sent++;
               end
               send_word(pixel_word(next_data_byte()));
               sent++;
            end
         end
      end
   endtask

   task automatic test_backpressure();
      settle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_config(bmp_rpu_pkg::DEPTH_1, 128, 1);
      send_word(ctrl_word(bmp_rpu_pkg::ACT_RESTART));
      fork
         begin
            rsp_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end
         begin
            repeat (24) send_word(pixel_word(8'($urandom_range(0, 255))));
         end
      join
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.action = bmp_rpu_pkg::ACT_PAL_WRITE;
      req_bus.data_byte = '0;
      req_bus.palette_index = '0;
      req_bus.palette_red = '0;
      req_bus.palette_green = '0;
      req_bus.palette_blue = '0;
      rsp_bus.ready = 1'b0;
      rsp_hold = 1'b0;
      fail_count = 0;
      cycle_count = 0;
      send_idle_pct = 11;
      recv_idle_pct = 60;
      cfg_depth = bmp_rpu_pkg::DEPTH_8;
      cfg_width = 13'd1;
      cfg_height = 13'd1;
      col_cnt = '0;
      row_cnt = '0;
      pad_left = '0;
      rgb_phase = '0;
      held_blue = '0;
      held_green = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_one_bit_rows();
      test_true_color();
      test_dim_limits();
      load_palette();
      test_random_frames(11, 60, 60);
      test_random_frames(60, 11, 60);
      test_random_frames(0, 0, 60);
      test_backpressure();
      settle();

      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/bmp_rpu_pkg.sv
hdl/bmp_rpu_req_if.sv
hdl/bmp_rpu_rsp_if.sv
hdl/bmp_row_pixel_unpacker_unit.sv
sim/testbench.sv
